/* rtl/pfd_pkg.sv */
// Package for the filtered-derivative PID step: request codes, register
// indexes and fixed widths for the controller; its checker uses the request codes.
// No dependencies.
`default_nettype none

package pfd_pkg;

	// Request kind carried in tuser of the input beat.
	localparam int REQ_W = 2;
	typedef logic [REQ_W-1:0] req_t;

	localparam req_t REQ_COMPUTE = 2'd0;
	localparam req_t REQ_CLEAR   = 2'd1;
	localparam req_t REQ_PRELOAD = 2'd2;

	// Coefficients are signed fixed point, always 32 bits wide.
	localparam int COEF_W = 32;
	typedef logic signed [COEF_W-1:0] coef_t;

	// Configuration register indexes.
	localparam int CFG_ADDR_W = 3;
	typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

	localparam cfg_addr_t REG_COEF_PREV_OUTPUT  = 3'd0;
	localparam cfg_addr_t REG_COEF_PREV2_OUTPUT = 3'd1;
	localparam cfg_addr_t REG_COEF_ERROR        = 3'd2;
	localparam cfg_addr_t REG_COEF_PREV_ERROR   = 3'd3;
	localparam cfg_addr_t REG_COEF_PREV2_ERROR  = 3'd4;
	localparam cfg_addr_t REG_OUT_UPPER         = 3'd5;
	localparam cfg_addr_t REG_OUT_LOWER         = 3'd6;

endpackage

`default_nettype wire

/* rtl/pid_filtered_derivative_step.sv */
// Top level of the fixed-point PID step with filtered derivative.
// Depends on pfd_pkg for request codes, register indexes and widths.
`default_nettype none

// One beat per clock cycle while no held result stalls the input. A beat
// is captured in an input register; from there five parallel coefficient
// multiplies, their sum, round-half-up, and the clamp run in one pass and
// load the result register and the controller history together. The
// history loop (the new drive feeds the next step's products) closes
// through that single pass and sets the clock limit. Clear and preload
// beats update the history and produce no result. The input side stalls
// only while a finished compute result is held in the output register and
// the next compute beat waits behind it. The user writes configuration
// through cfg_we/cfg_addr/cfg_wdata while the block is idle; the block does
// not enforce this. Indexes above the last register are ignored.
module pid_filtered_derivative_step #(
	parameter int SAMPLE_BITS    = 24,
	parameter int COEF_FRAC_BITS = 24
) (
	input  wire                                clk,
	input  wire                                arst_n,
	// Input beat.
	input  wire                                s_tvalid,
	output logic                               s_tready,
	// tdata fields from bit 0: target, measured, preload_value, zero pad.
	input  wire  [((3*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
	// tuser fields from bit 0: req_type.
	input  wire  [pfd_pkg::REQ_W-1:0]          s_tuser,
	// Result beat.
	output logic                               m_tvalid,
	input  wire                                m_tready,
	// tdata fields from bit 0: drive, zero pad.
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]   m_tdata,
	// Configuration write port.
	input  wire                                cfg_we,
	input  wire  [pfd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  wire  [pfd_pkg::COEF_W-1:0]         cfg_wdata
);

	localparam int S      = SAMPLE_BITS;
	localparam int F      = COEF_FRAC_BITS;
	localparam int OUT_W  = ((S + 7) / 8) * 8;
	localparam int PROD_W = pfd_pkg::COEF_W + S + 1;
	localparam int ACC_W  = PROD_W + 3;
	localparam int RES_W  = ACC_W - F;
	localparam logic [ACC_W-1:0] RND = ACC_W'(1) << (F - 1);
	localparam logic signed [S-1:0] SMAX = {1'b0, {(S-1){1'b1}}};
	localparam logic signed [S-1:0] SMIN = {1'b1, {(S-1){1'b0}}};

	// Configuration registers.
	pfd_pkg::coef_t cp_q, cp2_q, ce_q, ce1_q, ce2_q;
	logic signed [S-1:0] upper_q, lower_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_q    <= '0;
			cp2_q   <= '0;
			ce_q    <= '0;
			ce1_q   <= '0;
			ce2_q   <= '0;
			upper_q <= SMAX;
			lower_q <= SMIN;
		end else if (cfg_we) begin
			case (cfg_addr)
				pfd_pkg::REG_COEF_PREV_OUTPUT:  cp_q    <= cfg_wdata;
				pfd_pkg::REG_COEF_PREV2_OUTPUT: cp2_q   <= cfg_wdata;
				pfd_pkg::REG_COEF_ERROR:        ce_q    <= cfg_wdata;
				pfd_pkg::REG_COEF_PREV_ERROR:   ce1_q   <= cfg_wdata;
				pfd_pkg::REG_COEF_PREV2_ERROR:  ce2_q   <= cfg_wdata;
				pfd_pkg::REG_OUT_UPPER:         upper_q <= cfg_wdata[S-1:0];
				pfd_pkg::REG_OUT_LOWER:         lower_q <= cfg_wdata[S-1:0];
				default: ;
			endcase
		end
	end

	// Input register stage.
	logic                v_s1;
	pfd_pkg::req_t       req_s1;
	logic signed [S-1:0] tgt_s1, mea_s1, pre_s1;
	logic                out_free, go_s1;

	assign out_free = !m_tvalid || m_tready;
	// Only a compute beat needs the output register.
	assign go_s1    = v_s1 && ((req_s1 != pfd_pkg::REQ_COMPUTE) || out_free);
	assign s_tready = !v_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1 <= s_tuser;
			tgt_s1 <= s_tdata[S-1:0];
			mea_s1 <= s_tdata[2*S-1:S];
			pre_s1 <= s_tdata[3*S-1:2*S];
		end
	end

	// Controller history.
	logic signed [S:0]   last_err_q, older_err_q;
	logic signed [S-1:0] last_drv_q, older_drv_q;
	logic                seeded_q;

	// Single pass: error, five products, sum, rounding and clamp.
	logic signed [S:0]       err_c, ld_c, od_c;
	logic signed [PROD_W-1:0] p0, p1, p2, p3, p4;
	logic signed [ACC_W-1:0]  acc_c, accr_c;
	logic signed [RES_W-1:0]  res_c, up_c, lo_c;
	logic signed [S-1:0]      drive_c;

	always_comb begin
		err_c = {tgt_s1[S-1], tgt_s1} - {mea_s1[S-1], mea_s1};
		// While unseeded (after reset or clear, before any compute or preload) both past drives take the measurement.
		ld_c  = seeded_q ? {last_drv_q[S-1], last_drv_q} : {mea_s1[S-1], mea_s1};
		od_c  = seeded_q ? {older_drv_q[S-1], older_drv_q} : {mea_s1[S-1], mea_s1};
		p0 = PROD_W'(cp_q)  * PROD_W'(ld_c);
		p1 = PROD_W'(cp2_q) * PROD_W'(od_c);
		p2 = PROD_W'(ce_q)  * PROD_W'(err_c);
		p3 = PROD_W'(ce1_q) * PROD_W'(last_err_q);
		p4 = PROD_W'(ce2_q) * PROD_W'(older_err_q);
		acc_c = {{3{p0[PROD_W-1]}}, p0} + {{3{p1[PROD_W-1]}}, p1}
			+ {{3{p2[PROD_W-1]}}, p2} + {{3{p3[PROD_W-1]}}, p3}
			+ {{3{p4[PROD_W-1]}}, p4};
		accr_c = acc_c + $signed(RND);
		res_c  = accr_c[ACC_W-1:F];
		up_c   = {{(RES_W-S){upper_q[S-1]}}, upper_q};
		lo_c   = {{(RES_W-S){lower_q[S-1]}}, lower_q};
		// When the limits cross, a result above the upper limit takes it and any other takes the lower
		// limit; either limit already lies in the sample range, so no further saturation is needed.
		if (res_c > up_c) begin
			drive_c = upper_q;
		end else if (res_c < lo_c) begin
			drive_c = lower_q;
		end else begin
			drive_c = res_c[S-1:0];
		end
	end

	// History update per request kind.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q  <= '0;
			older_err_q <= '0;
			last_drv_q  <= '0;
			older_drv_q <= '0;
			seeded_q    <= 1'b0;
		end else if (go_s1) begin
			case (req_s1)
				pfd_pkg::REQ_COMPUTE: begin
					older_err_q <= last_err_q;
					last_err_q  <= err_c;
					older_drv_q <= ld_c[S-1:0];
					last_drv_q  <= drive_c;
					seeded_q    <= 1'b1;
				end
				pfd_pkg::REQ_CLEAR: begin
					last_err_q  <= '0;
					older_err_q <= '0;
					last_drv_q  <= '0;
					older_drv_q <= '0;
					seeded_q    <= 1'b0;
				end
				pfd_pkg::REQ_PRELOAD: begin
					last_err_q  <= '0;
					older_err_q <= '0;
					last_drv_q  <= pre_s1;
					older_drv_q <= pre_s1;
					seeded_q    <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Output register.
	logic [S-1:0] drive_q;
	logic         take_c;

	assign take_c = go_s1 && (req_s1 == pfd_pkg::REQ_COMPUTE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (take_c) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_c) begin
			drive_q <= drive_c;
		end
	end

	assign m_tdata = OUT_W'(drive_q);

endmodule

`default_nettype wire

/* rtl/pfd_checker.sv */
// Port-level checker for the PID step, bound to the top level.
// Depends on pfd_pkg for the request codes.
`default_nettype none

module pfd_checker #(
	parameter int SAMPLE_BITS = 24
) (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              s_tvalid,
	input wire                              s_tready,
	input wire [pfd_pkg::REQ_W-1:0]         s_tuser,
	input wire                              m_tvalid,
	input wire                              m_tready,
	input wire [((SAMPLE_BITS+7)/8)*8-1:0]  m_tdata
);

	// A held result beat keeps its data.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// The input side stalls only behind a result that is not taken.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a held result");

	// A fresh result follows a compute beat accepted through the input register.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready
			&& (s_tuser == pfd_pkg::REQ_COMPUTE), 2))
		else $error("result beat without a compute beat");

endmodule

bind pid_filtered_derivative_step pfd_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_pfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
